// ----- sv/assert_macros.svh -----
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define AST_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// condition must hold at every clock edge out of reset
`define AST_ALWAYS(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
		else $error("assertion failed");

`else

`define AST_IMPLY(lbl, clk, rstn, ante, cons)
`define AST_ALWAYS(lbl, clk, rstn, cond)

`endif

`endif

// ----- sv/ccdp_pkg.sv -----
package ccdp_pkg;

	localparam int KW_COUNT    = 12;
	localparam int FIRST_TIMED = 8;
	localparam int KW_CHARS    = 16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_EQUAL = 8'h3d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef logic [2:0] status_t;
	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_NO_EQUAL  = 3'd1;
	localparam status_t ST_BAD_DELTA = 3'd2;
	localparam status_t ST_UNKNOWN   = 3'd3;
	localparam status_t ST_EMPTY     = 3'd4;

	// keyword text, left aligned, padded with spaces (never compared past length)
	localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
		"no-cache        ",
		"no-store        ",
		"no-transform    ",
		"only-if-cached  ",
		"public          ",
		"private         ",
		"must-revalidate ",
		"proxy-revalidate",
		"max-age         ",
		"max-stale       ",
		"min-fresh       ",
		"s-maxage        "
	};

	localparam logic [4:0] KW_LEN [KW_COUNT] = '{
		5'd8, 5'd8, 5'd12, 5'd14, 5'd6, 5'd7, 5'd15, 5'd16, 5'd7, 5'd9, 5'd9, 5'd8
	};

endpackage

// ----- sv/cache_control_directive_parser_core.sv -----
// path: a request is held in the input register, then parsed into the result register once that is free or draining, and taken from there
// throughput: one byte per cycle while the result side does not stall, as keyword match and decimal accumulate are combinational
// a byte that closes no directive produces no result
// reset: arst_n low clears the parser to keyword start and empties both register stages at once
`include "assert_macros.svh"

module cache_control_directive_parser_core
	import ccdp_pkg::*;
#(
	parameter int DELTA_BITS = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// input request stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,  // text_byte
	input  logic                   s_axis_tlast,  // end_of_value
	// result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// from bit 0 up: directive_code(4), delta_seconds(DELTA_BITS), has_delta(1),
	// status(3), zero pad to whole bytes
	output logic [((DELTA_BITS+8+7)/8)*8-1:0] m_axis_tdata,
	output logic                   m_axis_tlast   // last_result
);

	localparam int ACC_W = DELTA_BITS + 4;   // room for acc*10+digit before saturation check

	typedef enum logic [2:0] {
		PH_START       = 3'd0,
		PH_KEYWORD     = 3'd1,
		PH_DELTA_FIRST = 3'd2,
		PH_DELTA_MORE  = 3'd3,
		PH_DROP        = 3'd4
	} phase_t;

	// lowest candidate whose full length equals the position, else KW_COUNT
	function automatic logic [3:0] complete_kw(input logic [KW_COUNT-1:0] mask,
		input logic [4:0] pos);
		logic [3:0] r;
		r = 4'(KW_COUNT);
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (mask[k] && KW_LEN[k] == pos)
				r = 4'(k);
		end
		return r;
	endfunction

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// parser state
	phase_t                phase_q;
	logic [KW_COUNT-1:0]   cand_q;
	logic [4:0]            pos_q;
	logic [3:0]            match_q;
	logic [DELTA_BITS-1:0] acc_q;

	// result register
	logic                  out_valid_q;
	logic [3:0]            out_code_q;
	logic [DELTA_BITS-1:0] out_delta_q;
	logic                  out_has_q;
	status_t               out_status_q;
	logic                  out_last_q;

	// handshake: the byte in stage 1 is parsed when the result slot is free or draining
	logic slot_free, fire;
	assign slot_free     = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && slot_free;
	assign s_axis_tready = !valid_s1 || fire;

	// next state and result
	phase_t                ph_n;
	logic [KW_COUNT-1:0]   cand_n;
	logic [4:0]            pos_n;
	logic [3:0]            match_n;
	logic [DELTA_BITS-1:0] acc_n;
	logic                  emit;
	logic [3:0]            r_code;
	logic [DELTA_BITS-1:0] r_delta;
	logic                  r_has;
	status_t               r_status;
	logic                  r_last;
	logic                  clr;
	logic                  to_drop;

	// match helpers: in the start phase the keyword begins afresh
	logic [KW_COUNT-1:0] eff_cand, step_mask;
	logic [4:0]          eff_pos, pos_adv;
	logic [3:0]          kw_now, kw_next;
	logic                is_digit;
	logic [ACC_W-1:0]    acc_ext, acc_mul;
	logic                acc_sat;
	logic [DELTA_BITS-1:0] acc_digit;

	always_comb begin
		eff_cand = (phase_q == PH_START) ? {KW_COUNT{1'b1}} : cand_q;
		eff_pos  = (phase_q == PH_START) ? 5'd0 : pos_q;
		pos_adv  = (eff_pos != 5'd31) ? eff_pos + 5'd1 : eff_pos;
		for (int k = 0; k < KW_COUNT; k++) begin
			step_mask[k] = eff_cand[k] && (eff_pos < KW_LEN[k]) &&
				(KW_TEXT[k][8*(KW_CHARS-1-int'(eff_pos[3:0])) +: 8] == byte_s1);
		end
		kw_now  = complete_kw(eff_cand, eff_pos);
		kw_next = complete_kw(step_mask, pos_adv);
	end

	// decimal accumulate: acc*10 + digit as two shifts and adds, saturate on carry out
	always_comb begin
		is_digit  = byte_s1 inside {[CH_ZERO:CH_NINE]};
		acc_ext   = ACC_W'(acc_q);
		acc_mul   = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(byte_s1[3:0]);
		acc_sat   = (acc_mul[ACC_W-1:DELTA_BITS] != 4'd0);
		acc_digit = acc_sat ? {DELTA_BITS{1'b1}} : acc_mul[DELTA_BITS-1:0];
	end

	always_comb begin
		ph_n     = phase_q;
		cand_n   = cand_q;
		pos_n    = pos_q;
		match_n  = match_q;
		acc_n    = acc_q;
		emit     = 1'b0;
		r_code   = 4'd0;
		r_delta  = '0;
		r_has    = 1'b0;
		r_status = ST_OK;
		r_last   = 1'b0;
		clr      = 1'b0;
		to_drop  = 1'b0;

		case (phase_q)
			PH_START, PH_KEYWORD: begin
				if (phase_q == PH_START && (byte_s1 inside {CH_SPACE, CH_COMMA})) begin
					// separator skip; a trailing one ends the value with nothing parsed
					if (end_s1) begin
						emit     = 1'b1;
						r_status = ST_EMPTY;
						r_last   = 1'b1;
						clr      = 1'b1;
					end
				end else if (byte_s1 == CH_COMMA) begin
					emit = 1'b1;
					clr  = 1'b1;
					if (kw_now < 4'(FIRST_TIMED)) begin
						r_code = kw_now;
						r_last = end_s1;
					end else begin
						r_status = (kw_now < 4'(KW_COUNT)) ? ST_NO_EQUAL : ST_UNKNOWN;
						r_last   = 1'b1;
						to_drop  = !end_s1;
					end
				end else if (byte_s1 == CH_EQUAL) begin
					if (kw_now >= 4'(FIRST_TIMED) && kw_now < 4'(KW_COUNT)) begin
						match_n = kw_now;
						acc_n   = '0;
						ph_n    = PH_DELTA_FIRST;
						if (end_s1) begin
							// '=' on the last byte: no digits
							emit     = 1'b1;
							r_status = ST_BAD_DELTA;
							r_last   = 1'b1;
							clr      = 1'b1;
						end
					end else begin
						emit     = 1'b1;
						r_status = ST_UNKNOWN;
						r_last   = 1'b1;
						clr      = 1'b1;
						to_drop  = !end_s1;
					end
				end else begin
					cand_n = step_mask;
					pos_n  = pos_adv;
					ph_n   = PH_KEYWORD;
					if (step_mask == '0) begin
						emit     = 1'b1;
						r_status = ST_UNKNOWN;
						r_last   = 1'b1;
						clr      = 1'b1;
						to_drop  = !end_s1;
					end else if (end_s1) begin
						emit = 1'b1;
						clr  = 1'b1;
						r_last = 1'b1;
						if (kw_next < 4'(FIRST_TIMED))
							r_code = kw_next;
						else
							r_status = (kw_next < 4'(KW_COUNT)) ? ST_NO_EQUAL : ST_UNKNOWN;
					end
				end
			end
			PH_DELTA_FIRST, PH_DELTA_MORE: begin
				if (is_digit) begin
					acc_n = acc_digit;
					ph_n  = PH_DELTA_MORE;
					if (end_s1) begin
						emit    = 1'b1;
						r_code  = match_q;
						r_delta = acc_digit;
						r_has   = 1'b1;
						r_last  = 1'b1;
						clr     = 1'b1;
					end
				end else if (byte_s1 == CH_COMMA && phase_q == PH_DELTA_MORE) begin
					emit    = 1'b1;
					r_code  = match_q;
					r_delta = acc_q;
					r_has   = 1'b1;
					r_last  = end_s1;
					clr     = 1'b1;
				end else begin
					emit     = 1'b1;
					r_status = ST_BAD_DELTA;
					r_last   = 1'b1;
					clr      = 1'b1;
					to_drop  = !end_s1;
				end
			end
			default: begin
				// drop to the end flag; unused codes act the same
				if (end_s1)
					clr = 1'b1;
			end
		endcase

		if (clr) begin
			ph_n    = to_drop ? PH_DROP : PH_START;
			cand_n  = {KW_COUNT{1'b1}};
			pos_n   = 5'd0;
			match_n = 4'd0;
			acc_n   = '0;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tlast;
		end
	end

	// parser state and result register, advanced once per parsed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_START;
			cand_q       <= {KW_COUNT{1'b1}};
			pos_q        <= 5'd0;
			match_q      <= 4'd0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
			out_code_q   <= 4'd0;
			out_delta_q  <= '0;
			out_has_q    <= 1'b0;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b0;
		end else begin
			if (fire) begin
				phase_q     <= ph_n;
				cand_q      <= cand_n;
				pos_q       <= pos_n;
				match_q     <= match_n;
				acc_q       <= acc_n;
				out_valid_q <= emit;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (fire && emit) begin
				out_code_q   <= r_code;
				out_delta_q  <= r_delta;
				out_has_q    <= r_has;
				out_status_q <= r_status;
				out_last_q   <= r_last;
			end
		end
	end

	always_comb begin
		m_axis_tdata                             = '0;
		m_axis_tdata[3:0]                        = out_code_q;
		m_axis_tdata[DELTA_BITS+3:4]             = out_delta_q;
		m_axis_tdata[DELTA_BITS+4]               = out_has_q;
		m_axis_tdata[DELTA_BITS+7:DELTA_BITS+5]  = out_status_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;

	// error results always close the value and carry no directive
	`AST_IMPLY(a_err_closes, clk, arst_n, out_valid_q && out_status_q != ST_OK,
		out_last_q && out_code_q == 4'd0 && !out_has_q)
	// a timed result only names a timed keyword
	`AST_IMPLY(a_has_timed, clk, arst_n, out_valid_q && out_has_q,
		out_code_q >= 4'(FIRST_TIMED) && out_code_q < 4'(KW_COUNT))
	// while inside a keyword at least one candidate is alive and position stays in range
	`AST_IMPLY(a_kw_alive, clk, arst_n, phase_q == PH_KEYWORD,
		cand_q != '0 && pos_q <= 5'd16)
	// delta phases only follow a timed keyword
	`AST_IMPLY(a_delta_timed, clk, arst_n,
		phase_q == PH_DELTA_FIRST || phase_q == PH_DELTA_MORE,
		match_q >= 4'(FIRST_TIMED) && match_q < 4'(KW_COUNT))

endmodule

// ----- verif/tb_cache_control_directive_parser_core.sv -----
module tb_cache_control_directive_parser_core;
	import ccdp_pkg::*;

	localparam int DELTA_W = 31;
	localparam int RES_W = ((DELTA_W + 8 + 7) / 8) * 8;
	localparam logic [63:0] DELTA_MAX = (64'd1 << DELTA_W) - 64'd1;
	localparam int ITEM_TARGET = 1050;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PROBE_ROWS = 23;

	// error results carry a zero directive code
	localparam logic [3:0] NO_DIRECTIVE = 4'd0;

	typedef enum logic [3:0] {
		DIR_NO_CACHE, DIR_NO_STORE, DIR_NO_TRANSFORM, DIR_ONLY_IF_CACHED,
		DIR_PUBLIC, DIR_PRIVATE, DIR_MUST_REVALIDATE, DIR_PROXY_REVALIDATE,
		DIR_MAX_AGE, DIR_MAX_STALE, DIR_MIN_FRESH, DIR_S_MAXAGE
	} directive_e;

	typedef enum logic [2:0] {
		SCAN_START, SCAN_WORD, SCAN_DIGIT_FIRST, SCAN_DIGIT_MORE, SCAN_SKIP
	} scan_phase_e;

	typedef struct packed {
		logic [3:0]         code;
		logic [DELTA_W-1:0] delta;
		logic               has;
		status_t            status;
		logic               last;
	} dir_result_t;

	typedef struct {
		string       text;
		bit          typed;
		dir_result_t want;
	} probe_row_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = 8'h00;
	logic             s_axis_tlast = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [RES_W-1:0] m_axis_tdata;
	logic             m_axis_tlast;

	string kw_name [KW_COUNT] = '{
		"no-cache", "no-store", "no-transform", "only-if-cached",
		"public", "private", "must-revalidate", "proxy-revalidate",
		"max-age", "max-stale", "min-fresh", "s-maxage"
	};

	// directed values; typed rows hold the single result they must give
	probe_row_t probe_tbl [PROBE_ROWS] = '{
		'{"no-cache", 1'b1, '{DIR_NO_CACHE, 31'd0, 1'b0, ST_OK, 1'b1}},
		'{"proxy-revalidate", 1'b1, '{DIR_PROXY_REVALIDATE, 31'd0, 1'b0, ST_OK, 1'b1}},
		'{" max-age=0", 1'b1, '{DIR_MAX_AGE, 31'd0, 1'b1, ST_OK, 1'b1}},
		'{"s-maxage=2147483647", 1'b1,
			'{DIR_S_MAXAGE, 31'h7fffffff, 1'b1, ST_OK, 1'b1}},
		'{"max-stale=99999999999", 1'b1,
			'{DIR_MAX_STALE, 31'h7fffffff, 1'b1, ST_OK, 1'b1}},
		'{"min-fresh", 1'b1, '{NO_DIRECTIVE, 31'd0, 1'b0, ST_NO_EQUAL, 1'b1}},
		'{"max-age=", 1'b1, '{NO_DIRECTIVE, 31'd0, 1'b0, ST_BAD_DELTA, 1'b1}},
		'{"max-age=12x3", 1'b1, '{NO_DIRECTIVE, 31'd0, 1'b0, ST_BAD_DELTA, 1'b1}},
		'{"public=5", 1'b1, '{NO_DIRECTIVE, 31'd0, 1'b0, ST_UNKNOWN, 1'b1}},
		'{"No-cache", 1'b1, '{NO_DIRECTIVE, 31'd0, 1'b0, ST_UNKNOWN, 1'b1}},
		'{" , ,", 1'b1, '{NO_DIRECTIVE, 31'd0, 1'b0, ST_EMPTY, 1'b1}},
		'{"private,", 1'b1, '{DIR_PRIVATE, 31'd0, 1'b0, ST_OK, 1'b1}},
		'{"no-", 1'b1, '{NO_DIRECTIVE, 31'd0, 1'b0, ST_UNKNOWN, 1'b1}},
		'{"max-age=5,", 1'b1, '{DIR_MAX_AGE, 31'd5, 1'b1, ST_OK, 1'b1}},
		'{"max-age=,x", 1'b1, '{NO_DIRECTIVE, 31'd0, 1'b0, ST_BAD_DELTA, 1'b1}},
		'{"max-age,z", 1'b1, '{NO_DIRECTIVE, 31'd0, 1'b0, ST_NO_EQUAL, 1'b1}},
		'{"must-revalidatex", 1'b1, '{NO_DIRECTIVE, 31'd0, 1'b0, ST_UNKNOWN, 1'b1}},
		'{"no-store, no-transform,,only-if-cached", 1'b0, '0},
		'{"max-age=10,s-maxage=007, min-fresh=42,max-stale=1,public", 1'b0, '0},
		'{"must-revalidate,private, ,", 1'b0, '0},
		'{"no-cache ,no-store", 1'b0, '0},
		'{"max-age=4294967296,no-cache", 1'b0, '0},
		'{"proxy-revalidate,max-age=1=", 1'b0, '0}
	};

	// parser image kept by the testbench
	scan_phase_e scan_phase;
	logic [11:0] scan_cand;
	logic [4:0]  scan_pos;
	logic [3:0]  scan_dir;
	logic [63:0] scan_acc;

	dir_result_t pending [$];
	logic [7:0]  text_q [$];
	int          mismatch_count = 0;
	int          live_bytes = 0;
	int          src_gap_pct = 20;
	int          sink_stall_pct = 20;

	cache_control_directive_parser_core #(
		.DELTA_BITS(DELTA_W)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic log_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	function automatic int gap_len(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		// mostly short holes, now and then a long one
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	// append to the tail of the text and prediction queues
	function automatic void add_text_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	function automatic void add_pending(input dir_result_t r);
		pending.insert(pending.size(), r);
	endfunction

	function automatic void clear_scan();
		scan_phase = SCAN_START;
		scan_cand  = '1;
		scan_pos   = '0;
		scan_dir   = '0;
		scan_acc   = '0;
	endfunction

	function automatic bit emit(output dir_result_t r, input logic [3:0] code,
			input logic [63:0] delta, input logic has, input status_t st, input logic last);
		r.code   = code;
		r.delta  = delta[DELTA_W-1:0];
		r.has    = has;
		r.status = st;
		r.last   = last;
		clear_scan();
		return 1'b1;
	endfunction

	// error: one closing result, then drop up to the end flag
	function automatic bit reject(output dir_result_t r, input status_t st, input bit eov);
		void'(emit(r, NO_DIRECTIVE, 64'd0, 1'b0, st, 1'b1));
		if (!eov)
			scan_phase = SCAN_SKIP;
		return 1'b1;
	endfunction

	// keyword still alive whose full length has been seen, else KW_COUNT
	function automatic int complete_word();
		for (int k = 0; k < KW_COUNT; k++)
			if (scan_cand[k] && kw_name[k].len() == scan_pos)
				return k;
		return KW_COUNT;
	endfunction

	function automatic bit word_step(input logic [7:0] b, input bit eov,
			output dir_result_t r);
		int          k;
		logic [11:0] nxt;
		logic [7:0]  ch;
		r = '0;
		if (b == CH_COMMA) begin
			k = complete_word();
			if (k < FIRST_TIMED)
				return emit(r, 4'(k), 64'd0, 1'b0, ST_OK, eov);
			return reject(r, (k < KW_COUNT) ? ST_NO_EQUAL : ST_UNKNOWN, eov);
		end
		if (b == CH_EQUAL) begin
			k = complete_word();
			if (k >= FIRST_TIMED && k < KW_COUNT) begin
				scan_dir   = 4'(k);
				scan_acc   = '0;
				scan_phase = SCAN_DIGIT_FIRST;
				if (eov)
					return reject(r, ST_BAD_DELTA, eov);
				return 1'b0;
			end
			return reject(r, ST_UNKNOWN, eov);
		end
		nxt = '0;
		for (int j = 0; j < KW_COUNT; j++) begin
			if (scan_cand[j] && scan_pos < kw_name[j].len()) begin
				ch = kw_name[j][scan_pos];
				if (ch == b)
					nxt[j] = 1'b1;
			end
		end
		scan_cand = nxt;
		if (scan_pos < 5'd31)
			scan_pos++;
		if (scan_cand == '0)
			return reject(r, ST_UNKNOWN, eov);
		if (eov) begin
			k = complete_word();
			if (k < FIRST_TIMED)
				return emit(r, 4'(k), 64'd0, 1'b0, ST_OK, eov);
			return reject(r, (k < KW_COUNT) ? ST_NO_EQUAL : ST_UNKNOWN, eov);
		end
		return 1'b0;
	endfunction

	// one accepted byte into the parser image; 1 when it closes a result
	function automatic bit scan_byte(input logic [7:0] b, input bit eov,
			output dir_result_t r);
		logic [63:0] d;
		r = '0;
		case (scan_phase)
			SCAN_START: begin
				if (b == CH_SPACE || b == CH_COMMA) begin
					if (eov)
						return emit(r, NO_DIRECTIVE, 64'd0, 1'b0, ST_EMPTY, 1'b1);
					return 1'b0;
				end
				scan_cand  = '1;
				scan_pos   = '0;
				scan_phase = SCAN_WORD;
				return word_step(b, eov, r);
			end
			SCAN_WORD: return word_step(b, eov, r);
			SCAN_DIGIT_FIRST, SCAN_DIGIT_MORE: begin
				if (b >= CH_ZERO && b <= CH_NINE) begin
					d = 64'(b - CH_ZERO);
					// saturate instead of wrapping
					if (scan_acc > (DELTA_MAX - d) / 64'd10)
						scan_acc = DELTA_MAX;
					else
						scan_acc = scan_acc * 64'd10 + d;
					scan_phase = SCAN_DIGIT_MORE;
					if (eov)
						return emit(r, scan_dir, scan_acc, 1'b1, ST_OK, 1'b1);
					return 1'b0;
				end
				if (b == CH_COMMA && scan_phase == SCAN_DIGIT_MORE)
					return emit(r, scan_dir, scan_acc, 1'b1, ST_OK, eov);
				return reject(r, ST_BAD_DELTA, eov);
			end
			default: begin
				if (eov)
					clear_scan();
				return 1'b0;
			end
		endcase
	endfunction

	// one request on the input stream; valid drops only for a hole
	task automatic send_byte(input logic [7:0] b, input bit eov, input bit typed,
			input dir_result_t want);
		int          gap;
		dir_result_t got;
		gap = gap_len(src_gap_pct);
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= eov;
		do @(posedge clk); while (!s_axis_tready);
		if (scan_phase != SCAN_SKIP)
			live_bytes++;
		if (scan_byte(b, eov, got))
			add_pending(typed ? want : got);
	endtask

	task automatic send_text(input bit typed, input dir_result_t want);
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1, typed, want);
	endtask

	// hold the input side until every result has come out
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] sep_byte();
		return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_COMMA;
	endfunction

	function automatic void add_word(input int k);
		for (int i = 0; i < kw_name[k].len(); i++)
			add_text_byte(kw_name[k][i]);
	endfunction

	// a list of directives with random separators and delta values
	function automatic void compose_list();
		int n;
		int k;
		int ndig;
		n = $urandom_range(1, 4);
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
			add_text_byte(sep_byte());
		for (int i = 0; i < n; i++) begin
			if (i > 0) begin
				add_text_byte(CH_COMMA);
				repeat ($urandom_range(0, 2)) add_text_byte(sep_byte());
			end
			k = $urandom_range(0, KW_COUNT - 1);
			add_word(k);
			if (k >= FIRST_TIMED) begin
				add_text_byte(CH_EQUAL);
				// long runs now and then to reach saturation
				ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
				repeat (ndig) add_text_byte(CH_ZERO + 8'($urandom_range(0, 9)));
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			add_text_byte(CH_COMMA);
			repeat ($urandom_range(0, 2)) add_text_byte(sep_byte());
		end
	endfunction

	function automatic void compose_header();
		int kind;
		int pos;
		text_q.delete();
		kind = $urandom_range(0, 99);
		if (kind < 90) begin
			compose_list();
			if (kind >= 75) begin
				// damaged list: stray byte, flipped bit or cut short
				pos = $urandom_range(0, text_q.size() - 1);
				case ($urandom_range(0, 2))
					0: text_q[pos] = 8'($urandom_range(0, 255));
					1: text_q[pos] = text_q[pos] ^ 8'(1 << $urandom_range(0, 7));
					default: while (text_q.size() > pos + 1) void'(text_q.pop_back());
				endcase
			end
		end else begin
			// short noise leaning on the bytes the parser cares about
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 4))
					0: add_text_byte(sep_byte());
					1: add_text_byte(CH_EQUAL);
					2: add_text_byte(CH_ZERO + 8'($urandom_range(0, 9)));
					3: add_text_byte(8'($urandom_range(8'h61, 8'h7a)));
					default: add_text_byte(8'($urandom_range(0, 255)));
				endcase
			end
		end
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	// result side stalls
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				stall_left = gap_len(sink_stall_pct);
				if (stall_left > 0) begin
					stall_left--;
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	// compare each result with the oldest prediction
	always @(posedge clk) begin : result_check
		dir_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending.size() == 0) begin
				log_mismatch($sformatf("result with nothing pending, data %h last %b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				want = pending.pop_front();
				check_field("directive_code", 64'(m_axis_tdata[3:0]), 64'(want.code));
				check_field("delta_seconds", 64'(m_axis_tdata[DELTA_W+3:4]),
					64'(want.delta));
				check_field("has_delta", 64'(m_axis_tdata[DELTA_W+4]), 64'(want.has));
				check_field("status", 64'(m_axis_tdata[DELTA_W+7:DELTA_W+5]),
					64'(want.status));
				check_field("last_result", 64'(m_axis_tlast), 64'(want.last));
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("cache_control_directive_parser_core verification failed");
		$finish;
	end

	initial begin : stimulus
		int value_idx;
		clear_scan();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed values
		for (int r = 0; r < PROBE_ROWS; r++) begin
			text_q.delete();
			for (int i = 0; i < probe_tbl[r].text.len(); i++)
				add_text_byte(probe_tbl[r].text[i]);
			send_text(probe_tbl[r].typed, probe_tbl[r].want);
		end
		drain_results();

		// random values, idle pattern changing in stretches
		value_idx = 0;
		while (live_bytes < ITEM_TARGET) begin
			if (value_idx % 25 == 0) begin
				src_gap_pct    = pick_pct();
				sink_stall_pct = pick_pct();
			end
			compose_header();
			send_text(1'b0, '0);
			if (value_idx % 150 == 149)
				drain_results();
			value_idx++;
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("cache_control_directive_parser_core verification clean");
		else
			$display("cache_control_directive_parser_core verification failed");
		$finish;
	end

endmodule
